// File: hdl/npl_pkg.sv
// npl_pkg: shared types and constants for the nearest point and path length unit.
// Used by npl_ctrl, npl_dp and the top level; depends on nothing.
package npl_pkg;

  localparam int unsigned MAX_POINTS = 256;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SQ_W    = 33;  // dx*dx + dy*dy
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned PATH_W  = 25;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic set_ovf;
    logic start_set;
    logic rd_prev;
    logic mul;
    logic scan_init;
    logic scan_cmp;
    logic sqrt_load;
    logic sqrt_sel_best;
    logic sqrt_step;
    logic path_upd;
    logic out_load;
    logic out_short;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic cnt_lt2;
    logic scan_last;
    logic sqrt_last;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/npl_ram.sv
// npl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module npl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/npl_ctrl.sv
// npl_ctrl: sequencer for load, append and query items.
// Depends on npl_pkg; drives cmd_t to npl_dp and reads its sts_t.
module npl_ctrl import npl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SET  = 9'b000000010,
    S_RD   = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_ADD  = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_PATH = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    M_APP   = 2'd0,
    M_QRY   = 2'd1,
    M_SHORT = 2'd2
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    mode_d  = mode_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (opcode_i)
            OP_START: state_d = S_SET;
            OP_APPEND: begin
              if (sts_i.cnt_full) begin
                cmd_o.set_ovf = 1'b1;
              end else if (sts_i.cnt_zero) begin
                state_d = S_PATH;  // first point: nothing to measure
              end else begin
                mode_d  = M_APP;
                state_d = S_RD;
              end
            end
            OP_QUERY: begin
              if (sts_i.cnt_lt2) begin
                mode_d  = M_SHORT;
                state_d = S_OUT;
              end else begin
                mode_d          = M_QRY;
                cmd_o.scan_init = 1'b1;
                state_d         = S_RD;
              end
            end
            default: ;  // unused opcode, item dropped
          endcase
        end
      end
      S_SET: begin
        cmd_o.start_set = 1'b1;
        state_d         = S_IDLE;
      end
      S_RD: begin
        cmd_o.rd_prev = (mode_q == M_APP);
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        if (mode_q == M_APP) begin
          cmd_o.sqrt_load = 1'b1;
          state_d         = S_SQRT;
        end else begin
          cmd_o.scan_cmp = 1'b1;
          if (sts_i.scan_last) begin
            cmd_o.sqrt_load     = 1'b1;
            cmd_o.sqrt_sel_best = 1'b1;
            state_d             = S_SQRT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = (mode_q == M_APP) ? S_PATH : S_OUT;
        end
      end
      S_PATH: begin
        cmd_o.path_upd = 1'b1;
        state_d        = S_IDLE;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_short = (mode_q == M_SHORT);
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_APP;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

// File: hdl/npl_dp.sv
// npl_dp: point store, squared-distance datapath, bit-pair square root,
// path accumulator and result register. Depends on npl_pkg and npl_ram.
module npl_dp import npl_pkg::*; #(
  parameter int unsigned MaxPoints = MAX_POINTS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [7:0]                nearest_index_o,
  output logic [DIST_W-1:0]         nearest_distance_o,
  output logic [PATH_W-1:0]         path_length_o,
  output logic [STAT_W-1:0]         status_o
);

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned PW   = 2 * COORD_W;

  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic [CntW-1:0]           cnt_q, cnt_m1;
  logic [PATH_W-1:0]         path_q;
  logic                      ovf_q;
  logic [IdxW-1:0]           idx_q, best_idx_q;
  logic                      first_q;
  logic [SQ_W-1:0]           best_q, best_next, sum;
  logic [SQ_W-2:0]           sqx_q, sqy_q;
  logic [SQ_W-1:0]           v_q, bit_q;
  logic [SQ_W:0]             res_q, trial;
  logic                      upd;
  logic [PATH_W:0]           path_sum;

  // point store
  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr, ram_raddr;
  logic [PW-1:0]             ram_rdata;

  assign cnt_m1    = cnt_q - 1'b1;
  assign ram_we    = cmd_i.start_set | cmd_i.path_upd;
  assign ram_waddr = cmd_i.start_set ? '0 : cnt_q[IdxW-1:0];
  assign ram_raddr = cmd_i.rd_prev ? cnt_m1[IdxW-1:0] : idx_q;

  npl_ram #(
    .Width (PW),
    .Depth (MaxPoints)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({qx_q, qy_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // squares of the coordinate differences
  logic signed [COORD_W:0]     dx, dy;
  logic signed [2*COORD_W+1:0] dxx, dyy;

  always_comb begin
    dx  = $signed({ram_rdata[PW-1], ram_rdata[PW-1:COORD_W]}) - $signed({qx_q[COORD_W-1], qx_q});
    dy  = $signed({ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]})
          - $signed({qy_q[COORD_W-1], qy_q});
    dxx = dx * dx;
    dyy = dy * dy;
  end

  assign sum       = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign upd       = first_q || (sum < best_q);
  assign best_next = upd ? sum : best_q;
  assign trial     = res_q + {1'b0, bit_q};
  assign path_sum  = {1'b0, path_q} + (PATH_W + 1)'(res_q[DIST_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      qx_q <= x_coord_i;
      qy_q <= y_coord_i;
    end
    if (cmd_i.mul) begin
      sqx_q <= dxx[SQ_W-2:0];
      sqy_q <= dyy[SQ_W-2:0];
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.scan_cmp) begin
      idx_q <= idx_q + 1'b1;
      if (upd) begin
        best_q     <= sum;
        best_idx_q <= idx_q;
      end
    end
    // one result bit per step, bit walks down two places
    if (cmd_i.sqrt_load) begin
      v_q   <= cmd_i.sqrt_sel_best ? best_next : sum;
      res_q <= '0;
      bit_q <= {1'b1, {(SQ_W-1){1'b0}}};
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, v_q} >= trial) begin
        v_q   <= v_q - trial[SQ_W-1:0];
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      path_q  <= '0;
      ovf_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.scan_init) begin
        first_q <= 1'b1;
      end else if (cmd_i.scan_cmp) begin
        first_q <= 1'b0;
      end
      if (cmd_i.start_set) begin
        cnt_q  <= CntW'(1);
        path_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        if (cmd_i.set_ovf) begin
          ovf_q <= 1'b1;
        end
        if (cmd_i.path_upd) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q != '0) begin
            path_q <= path_sum[PATH_W] ? '1 : path_sum[PATH_W-1:0];
          end
        end
      end
    end
  end

  // result register
  logic                 out_valid_q;
  logic [7:0]           out_idx_q;
  logic [DIST_W-1:0]    out_dist_q;
  logic [PATH_W-1:0]    out_path_q;
  logic [STAT_W-1:0]    out_stat_q;
  logic [IdxW+7:0]      idx_wide;

  assign idx_wide = {8'd0, best_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_short) begin
        out_idx_q  <= '0;
        out_dist_q <= '0;
        out_path_q <= '0;
        out_stat_q <= ST_SHORT;
      end else begin
        out_idx_q  <= idx_wide[7:0];
        out_dist_q <= res_q[DIST_W-1:0];
        out_path_q <= path_q;
        out_stat_q <= ovf_q ? ST_OVF : ST_OK;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign nearest_index_o    = out_idx_q;
  assign nearest_distance_o = out_dist_q;
  assign path_length_o      = out_path_q;
  assign status_o           = out_stat_q;

  always_comb begin
    sts_o           = '0;
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.cnt_full  = (cnt_q >= CntW'(MaxPoints));
    sts_o.cnt_lt2   = (cnt_q < CntW'(2));
    sts_o.scan_last = ((CntW'(idx_q) + 1'b1) == cnt_q);
    sts_o.sqrt_last = bit_q[0];
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

// File: hdl/nearest_point_and_path_length_unit.sv
// nearest_point_and_path_length_unit: top level, joins npl_ctrl and npl_dp.
// Depends on npl_pkg, npl_ctrl, npl_dp (and npl_ram below it).
//
// Usage: one input channel (in_valid_i / in_stall_o) carries items of opcode,
// x and y (signed Q8.8). START begins a new point set, APPEND adds a point and
// adds the floor length of the new segment to the path sum, QUERY returns the
// first stored point nearest to (x, y), that floor distance, the path sum and
// a status on the output channel (out_valid_o / out_stall_i).
// Items are handled one at a time; in_stall_o is low only while idle.
// START stores the first point; APPEND runs the 17-step square root (one
//   result bit per cycle) and adds to the path sum; APPEND into an empty
//   set only stores the point; a dropped or unused item is only accepted;
//   QUERY on fewer than two points goes straight to the output; QUERY on N
//   points reads, squares and compares each stored point over the single
//   store read port, then takes the square root.
// Reset clears the point count, path sum and overflow flag; store contents
// are left as they are and never read before written. A result waits in
// the output register while out_stall_i is high; the next item is still
// taken, and a later query holds in its last state until the register frees.
module nearest_point_and_path_length_unit import npl_pkg::*; #(
  parameter int unsigned MaxPoints = MAX_POINTS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                opcode_i,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                nearest_index_o,
  output logic [DIST_W-1:0]         nearest_distance_o,
  output logic [PATH_W-1:0]         path_length_o,
  output logic [STAT_W-1:0]         status_o
);

  cmd_t cmd;
  sts_t sts;

  npl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  npl_dp #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .x_coord_i          (x_coord_i),
    .y_coord_i          (y_coord_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .nearest_index_o    (nearest_index_o),
    .nearest_distance_o (nearest_distance_o),
    .path_length_o      (path_length_o),
    .status_o           (status_o)
  );

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while previous one still pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sqrt_load |=> cmd.sqrt_step)
    else $error("square root loaded but not stepped");

  // a dropped append does not make the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == OP_APPEND && sts.cnt_full) |=> !in_stall_o)
    else $error("dropped append made the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_set |=> (!sts.cnt_zero && sts.cnt_lt2))
    else $error("new set does not hold exactly one point");

endmodule
